FILE: rtl/mse_pkg.sv
package mse_pkg;

    // Widths of the instruction and result fields
    localparam int WORD_W   = 32;
    localparam int REGNUM_W = 5;
    localparam int HALF_W   = 16;
    localparam int MODE_W   = 5;

    // Stream beat widths: fields packed from bit 0 up; the slave tdata is padded to whole bytes
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // Bit positions of the input fields inside the slave tdata
    localparam int SRC_LSB  = 0;
    localparam int SRC2_LSB = 5;
    localparam int DST_LSB  = 10;
    localparam int IMM_LSB  = 15;
    localparam int PC_LSB   = 31;
    localparam int JT_LSB   = 47;
    localparam int LV_LSB   = 63;

    // Reset value of the data base address register
    localparam logic [HALF_W-1:0] DATA_BASE_RESET = 16'd172;

    // Operation codes carried on the slave tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_NOP     = 5'd0,
        MODE_J       = 5'd1,
        MODE_JR      = 5'd2,
        MODE_BEQ     = 5'd3,
        MODE_BLTZ    = 5'd4,
        MODE_ADD     = 5'd5,
        MODE_ADDI    = 5'd6,
        MODE_SUB     = 5'd7,
        MODE_SW      = 5'd8,
        MODE_LW      = 5'd9,
        MODE_SLL     = 5'd10,
        MODE_SRL     = 5'd11,
        MODE_MUL     = 5'd12,
        MODE_AND     = 5'd13,
        MODE_OR      = 5'd14,
        MODE_MOVZ    = 5'd15,
        MODE_PRELOAD = 5'd16
    } t_mode;

    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [REGNUM_W-1:0] t_regnum;
    typedef logic [HALF_W-1:0]   t_half;

endpackage

FILE: rtl/mips_subset_execute_unit.sv
// An accepted instruction is registered into the execute stage, then into the result
// register that drives the result beat.
// Throughput: one instruction per cycle, sustained, including dependent back-to-back
// instructions and loads; only a stalled result stream holds the input side.
// Register file writeback happens in the cycle after the execute cycle and is forwarded.
// Reset (synchronous, active low) clears the register file and data memory through valid
// bits, empties the pipeline and sets the data base address to 172.
module mips_subset_execute_unit #(
    parameter int REG_COUNT  = 32,
    parameter int DATA_WORDS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: data base address
    input  logic                          i_cfg_we,
    input  logic [mse_pkg::HALF_W-1:0]    i_cfg_wdata,
    // Instruction stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata from bit 0: src_reg(5), src2_reg(5), dst_reg(5), immediate(16), pc(16),
    // jump_target(16), load_value(32), one zero pad bit
    input  logic [mse_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: mode(5)
    input  logic [mse_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    // Result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: target(16)
    output logic [mse_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // tuser from bit 0: redirect(1), fault(1)
    output logic [mse_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);
    import mse_pkg::*;

    localparam int RI_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int DI_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

    // Unpacked input fields
    t_regnum in_src;
    t_regnum in_src2;
    logic    in_src_ok;
    logic    in_src2_ok;

    assign in_src     = i_s_axis_tdata[SRC_LSB +: REGNUM_W];
    assign in_src2    = i_s_axis_tdata[SRC2_LSB +: REGNUM_W];
    assign in_src_ok  = (int'(in_src) < REG_COUNT);
    assign in_src2_ok = (int'(in_src2) < REG_COUNT);

    // Handshake and stage control
    logic s_fire;
    logic x_fire;
    logic r_x_vld;
    logic r_out_vld;

    assign x_fire          = r_x_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_x_vld || x_fire;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration register
    t_half r_data_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_base <= DATA_BASE_RESET;
        end else if (i_cfg_we) begin
            r_data_base <= i_cfg_wdata;
        end
    end

    // Register file storage with per-entry valid bits
    t_word                rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;

    // Writeback stage
    logic    r_w_vld;
    logic    r_w_we;
    logic    r_w_load;
    t_regnum r_w_addr;
    t_word   r_w_alu;
    t_word   r_dm_q;
    logic    r_dm_ok;
    t_word   w_data;
    logic    w_wr;

    assign w_data = r_w_load ? (r_dm_ok ? r_dm_q : '0) : r_w_alu;
    assign w_wr   = r_w_vld && r_w_we;

    // Execute stage input registers
    t_mode   r_x_mode;
    t_regnum r_x_src;
    t_regnum r_x_src2;
    t_regnum r_x_dst;
    t_half   r_x_imm;
    t_half   r_x_pc;
    t_half   r_x_jt;
    t_word   r_x_lv;
    t_word   r_rf_qa;
    t_word   r_rf_qb;
    logic    r_a_ok;
    logic    r_b_ok;
    logic    r_a_byp;
    logic    r_b_byp;
    t_word   r_a_byp_data;
    t_word   r_b_byp_data;

    // Operands: registered read, then forwarding from the older writeback
    t_word a_raw;
    t_word b_raw;
    t_word op_a;
    t_word op_b;

    assign a_raw = r_a_byp ? r_a_byp_data : (r_a_ok ? r_rf_qa : '0);
    assign b_raw = r_b_byp ? r_b_byp_data : (r_b_ok ? r_rf_qb : '0);
    assign op_a  = (w_wr && r_w_addr == r_x_src) ? w_data : a_raw;
    assign op_b  = (w_wr && r_w_addr == r_x_src2) ? w_data : b_raw;

    // Register file: read ports registered at accept, one write port from writeback
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_rf_qa <= rf_mem[in_src[RI_W-1:0]];
            r_rf_qb <= rf_mem[in_src2[RI_W-1:0]];
        end
        if (w_wr) begin
            rf_mem[r_w_addr[RI_W-1:0]] <= w_data;
        end
    end

    // Valid bits, operand bypass flags and execute stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_x_vld  <= 1'b0;
            r_a_byp  <= 1'b0;
            r_b_byp  <= 1'b0;
        end else begin
            if (w_wr) begin
                r_rf_vld[r_w_addr[RI_W-1:0]] <= 1'b1;
            end
            if (s_fire) begin
                r_x_vld <= 1'b1;
                r_a_byp <= w_wr && r_w_addr == in_src;
                r_b_byp <= w_wr && r_w_addr == in_src2;
            end else if (r_x_vld && !x_fire) begin
                // A held instruction keeps its forwarded operands
                r_a_byp <= 1'b1;
                r_b_byp <= 1'b1;
            end else if (x_fire) begin
                r_x_vld <= 1'b0;
            end
        end
    end

    // Execute stage payload
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_x_mode     <= t_mode'(i_s_axis_tuser);
            r_x_src      <= in_src;
            r_x_src2     <= in_src2;
            r_x_dst      <= i_s_axis_tdata[DST_LSB +: REGNUM_W];
            r_x_imm      <= i_s_axis_tdata[IMM_LSB +: HALF_W];
            r_x_pc       <= i_s_axis_tdata[PC_LSB +: HALF_W];
            r_x_jt       <= i_s_axis_tdata[JT_LSB +: HALF_W];
            r_x_lv       <= i_s_axis_tdata[LV_LSB +: WORD_W];
            r_a_ok       <= in_src_ok && r_rf_vld[in_src[RI_W-1:0]];
            r_b_ok       <= in_src2_ok && r_rf_vld[in_src2[RI_W-1:0]];
            r_a_byp_data <= w_data;
            r_b_byp_data <= w_data;
        end else if (r_x_vld && !x_fire) begin
            r_a_byp_data <= op_a;
            r_b_byp_data <= op_b;
        end
    end

    // Arithmetic and logic for the execute stage
    t_word           imm32;
    t_word           prod;
    t_half           br_target;
    logic [33:0]     mem_off;
    logic            mem_ok;
    logic            pre_ok;

    assign imm32     = {{(WORD_W-HALF_W){r_x_imm[HALF_W-1]}}, r_x_imm};
    assign prod      = op_a * op_b;
    assign br_target = r_x_pc + r_x_imm;
    assign mem_off   = {{2{op_a[WORD_W-1]}}, op_a} + {{2{imm32[WORD_W-1]}}, imm32}
                       - {18'd0, r_data_base};
    assign mem_ok    = !mem_off[33] && (mem_off[1:0] == 2'b00)
                       && (mem_off[33:2] < 32'(DATA_WORDS));
    assign pre_ok    = !r_x_imm[HALF_W-1] && (r_x_imm < HALF_W'(DATA_WORDS));

    // Operation decode
    logic            x_redirect;
    t_half           x_target;
    logic            x_fault;
    logic            x_wr;
    t_regnum         x_wr_addr;
    t_word           x_wr_val;
    logic            x_load;
    logic            dm_we;
    logic            dm_re;
    logic [DI_W-1:0] dm_idx;
    t_word           dm_wdata;

    always_comb begin
        x_redirect = 1'b0;
        x_target   = '0;
        x_fault    = 1'b0;
        x_wr       = 1'b0;
        x_wr_addr  = r_x_dst;
        x_wr_val   = '0;
        x_load     = 1'b0;
        dm_we      = 1'b0;
        dm_re      = 1'b0;
        dm_idx     = mem_off[DI_W+1:2];
        dm_wdata   = op_b;
        case (r_x_mode)
            MODE_J: begin
                x_redirect = 1'b1;
                x_target   = r_x_jt;
            end
            MODE_JR: begin
                x_redirect = 1'b1;
                x_target   = op_a[HALF_W-1:0];
            end
            MODE_BEQ: begin
                x_redirect = (op_a == op_b);
                x_target   = (op_a == op_b) ? br_target : '0;
            end
            MODE_BLTZ: begin
                x_redirect = op_a[WORD_W-1];
                x_target   = op_a[WORD_W-1] ? br_target : '0;
            end
            MODE_ADD: begin
                x_wr     = 1'b1;
                x_wr_val = op_a + op_b;
            end
            MODE_ADDI: begin
                x_wr      = 1'b1;
                x_wr_addr = r_x_src2;
                x_wr_val  = op_a + imm32;
            end
            MODE_SUB: begin
                x_wr     = 1'b1;
                x_wr_val = op_a - op_b;
            end
            MODE_SW: begin
                dm_we   = mem_ok;
                x_fault = !mem_ok;
            end
            MODE_LW: begin
                dm_re     = mem_ok;
                x_wr      = mem_ok;
                x_load    = 1'b1;
                x_wr_addr = r_x_src2;
                x_fault   = !mem_ok;
            end
            MODE_SLL: begin
                x_wr     = 1'b1;
                x_wr_val = op_b << r_x_imm[4:0];
            end
            MODE_SRL: begin
                x_wr     = 1'b1;
                x_wr_val = op_b >> r_x_imm[4:0];
            end
            MODE_MUL: begin
                x_wr     = 1'b1;
                x_wr_val = prod;
            end
            MODE_AND: begin
                x_wr     = 1'b1;
                x_wr_val = op_a & op_b;
            end
            MODE_OR: begin
                x_wr     = 1'b1;
                x_wr_val = op_a | op_b;
            end
            MODE_MOVZ: begin
                x_wr     = (op_b == '0);
                x_wr_val = op_a;
            end
            MODE_PRELOAD: begin
                dm_we    = pre_ok;
                dm_idx   = r_x_imm[DI_W-1:0];
                dm_wdata = r_x_lv;
                x_fault  = !pre_ok;
            end
            default: begin
                x_redirect = 1'b0;
            end
        endcase
    end

    // Data memory with per-entry valid bits; read data registered for writeback
    t_word                 dm_mem [DATA_WORDS];
    logic [DATA_WORDS-1:0] r_dm_vld;

    always_ff @(posedge i_clk) begin
        if (x_fire && dm_we) begin
            dm_mem[dm_idx] <= dm_wdata;
        end
        if (x_fire && dm_re) begin
            r_dm_q <= dm_mem[dm_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dm_vld <= '0;
            r_dm_ok  <= 1'b0;
        end else begin
            if (x_fire && dm_we) begin
                r_dm_vld[dm_idx] <= 1'b1;
            end
            if (x_fire && dm_re) begin
                r_dm_ok <= r_dm_vld[dm_idx];
            end
        end
    end

    // Writeback stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
            r_w_we  <= 1'b0;
        end else begin
            r_w_vld <= x_fire;
            r_w_we  <= x_fire && x_wr && (int'(x_wr_addr) < REG_COUNT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_fire) begin
            r_w_load <= x_load;
            r_w_addr <= x_wr_addr;
            r_w_alu  <= x_wr_val;
        end
    end

    // Result register
    logic  r_out_redirect;
    logic  r_out_fault;
    t_half r_out_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (x_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_fire) begin
            r_out_redirect <= x_redirect;
            r_out_target   <= x_target;
            r_out_fault    <= x_fault;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_target;
    assign o_m_axis_tuser  = {r_out_fault, r_out_redirect};

    // A faulting access never touches the data memory
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (x_fire && x_fault) |-> (!dm_we && !dm_re))
        else $error("data memory accessed by a faulting instruction");

    // A result never reports both a redirect and a fault
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("redirect and fault reported together");

    // Without a redirect the target is zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("nonzero target without redirect");

    // Every executed instruction is followed by writeback in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_fire |=> r_w_vld)
        else $error("executed instruction lost before writeback");

    // A register write never targets a number beyond the register file
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |-> (int'(r_w_addr) < REG_COUNT))
        else $error("register write beyond the register file");

endmodule
